### rtl/lcmeg_pkg.sv
// Sequencer state type for the gcd and lcm unit.
`timescale 1ns / 1ps

package lcmeg_pkg;

  // Sequencer states of the unit.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_MOD,
    ST_QUOT,
    ST_MUL,
    ST_FINISH
  } state_t;

endpackage

### rtl/lcm_via_euclid_gcd_unit.sv
// Top level of the gcd and lcm unit: Euclid loop and lcm on a bit-serial divider and multiplier.
//
//   channel  direction  handshake           payload
//   in       input      in_valid/in_ready   in_operand_a, in_operand_b
//   out      output     out_valid/out_ready out_lcm_value, out_gcd_value, out_both_zero_error
//
// With both operands nonzero an item runs the Euclid remainder steps, then the final a / gcd,
// then the product; each remainder and the final a / gcd run on the shared one-bit-per-cycle
// restoring divider, and the product runs on the shift-and-add multiplier. With a zero
// operand the quotient and product are skipped and at most one remainder step runs.
// Reset is synchronous and active low; it clears the sequencer and the output valid.
// A new item is taken while a finished result still waits in the output register; the
// sequencer stalls in its last state only while that register is still full.
`timescale 1ns / 1ps

module lcm_via_euclid_gcd_unit
  import lcmeg_pkg::*;
#(
  parameter int OPERAND_WIDTH = 31
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [OPERAND_WIDTH-1:0]     in_operand_a,
  input  logic [OPERAND_WIDTH-1:0]     in_operand_b,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [2*OPERAND_WIDTH-1:0]   out_lcm_value,
  output logic [OPERAND_WIDTH-1:0]     out_gcd_value,
  output logic                         out_both_zero_error
);

  localparam int W     = OPERAND_WIDTH;
  localparam int CNT_W = $clog2(W);

  state_t             state_r, state_nxt;
  logic [W-1:0]       a_r, a_nxt;
  logic [W-1:0]       b_r, b_nxt;
  logic [W-1:0]       x_r, x_nxt;
  logic [W-1:0]       y_r, y_nxt;
  logic [W-1:0]       q_r, q_nxt;
  logic [W-1:0]       rem_r, rem_nxt;
  logic [2*W-1:0]     p_r, p_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               err_r, err_nxt;
  logic               skip_r, skip_nxt;
  logic [2*W-1:0]     out_lcm_r, out_lcm_nxt;
  logic [W-1:0]       out_gcd_r, out_gcd_nxt;
  logic               out_err_r, out_err_nxt;
  logic               out_valid_r, out_valid_nxt;

  logic               cnt_last;
  logic               out_free;
  logic [W-1:0]       divisor;
  logic [W:0]         trial;
  logic [W:0]         diff;
  logic               div_ge;
  logic [W-1:0]       div_rem;
  logic [W-1:0]       div_q;
  logic [W:0]         mul_sum;

  assign cnt_last = (cnt_r == CNT_W'(W - 1));
  assign out_free = !out_valid_r || out_ready;

  // Restoring divider: one quotient bit per cycle, shared by the Euclid loop and a / gcd.
  assign divisor = (state_r == ST_MOD) ? y_r : x_r;
  assign trial   = {rem_r, q_r[W-1]};
  assign diff    = trial - {1'b0, divisor};
  assign div_ge  = !diff[W];
  assign div_rem = div_ge ? diff[W-1:0] : trial[W-1:0];
  assign div_q   = {q_r[W-2:0], div_ge};

  // Shift-and-add multiplier: the quotient leaves at the low end one bit per cycle.
  assign mul_sum = {1'b0, p_r[2*W-1:W]} + (q_r[0] ? {1'b0, b_r} : {(W+1){1'b0}});

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (y_r != '0)   state_nxt = ST_MOD;
        else if (!skip_r) state_nxt = ST_QUOT;
        else              state_nxt = ST_FINISH;
      end
      ST_MOD: begin
        if (cnt_last) state_nxt = ST_CHECK;
      end
      ST_QUOT: begin
        if (cnt_last) state_nxt = ST_MUL;
      end
      ST_MUL: begin
        if (cnt_last) state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = (state_r == ST_IDLE);
  end

  always_comb begin
    a_nxt         = a_r;
    b_nxt         = b_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    q_nxt         = q_r;
    rem_nxt       = rem_r;
    p_nxt         = p_r;
    cnt_nxt       = cnt_r;
    err_nxt       = err_r;
    skip_nxt      = skip_r;
    out_lcm_nxt   = out_lcm_r;
    out_gcd_nxt   = out_gcd_r;
    out_err_nxt   = out_err_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          a_nxt    = in_operand_a;
          b_nxt    = in_operand_b;
          x_nxt    = in_operand_a;
          y_nxt    = in_operand_b;
          err_nxt  = (in_operand_a == '0) && (in_operand_b == '0);
          skip_nxt = (in_operand_a == '0) || (in_operand_b == '0);
        end
      end
      ST_CHECK: begin
        // Load the divider with x for x mod y, or with a for a / gcd once y is zero.
        q_nxt   = (y_r != '0) ? x_r : a_r;
        rem_nxt = '0;
        cnt_nxt = '0;
      end
      ST_MOD: begin
        q_nxt   = div_q;
        rem_nxt = div_rem;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_last) begin
          x_nxt = y_r;
          y_nxt = div_rem;
        end
      end
      ST_QUOT: begin
        q_nxt   = div_q;
        rem_nxt = div_rem;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_last) begin
          p_nxt   = '0;
          cnt_nxt = '0;
        end
      end
      ST_MUL: begin
        q_nxt   = {1'b0, q_r[W-1:1]};
        p_nxt   = {mul_sum, p_r[W-1:1]};
        cnt_nxt = cnt_r + 1'b1;
      end
      ST_FINISH: begin
        if (out_free) begin
          // When either operand is zero the lcm is zero; x already holds the gcd.
          out_lcm_nxt   = skip_r ? '0 : p_r;
          out_gcd_nxt   = x_r;
          out_err_nxt   = err_r;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r       <= a_nxt;
    b_r       <= b_nxt;
    x_r       <= x_nxt;
    y_r       <= y_nxt;
    q_r       <= q_nxt;
    rem_r     <= rem_nxt;
    p_r       <= p_nxt;
    cnt_r     <= cnt_nxt;
    err_r     <= err_nxt;
    skip_r    <= skip_nxt;
    out_lcm_r <= out_lcm_nxt;
    out_gcd_r <= out_gcd_nxt;
    out_err_r <= out_err_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_lcm_value       = out_lcm_r;
  assign out_gcd_value       = out_gcd_r;
  assign out_both_zero_error = out_err_r;

endmodule

### tb/lcm_via_euclid_gcd_unit_checker.sv
// Result checker for the gcd and lcm unit: predicts each result and compares it field by field.
`timescale 1ns / 1ps

module lcm_via_euclid_gcd_unit_checker #(
  parameter int OPERAND_WIDTH = 31
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  logic [OPERAND_WIDTH-1:0]     in_operand_a,
  input  logic [OPERAND_WIDTH-1:0]     in_operand_b,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  logic [2*OPERAND_WIDTH-1:0]   out_lcm_value,
  input  logic [OPERAND_WIDTH-1:0]     out_gcd_value,
  input  logic                         out_both_zero_error,
  output int                           pending_count,
  output int                           fail_count,
  output int                           checked_count
);

  typedef logic [OPERAND_WIDTH-1:0]   operand_t;
  typedef logic [2*OPERAND_WIDTH-1:0] lcm_t;

  typedef struct packed {
    lcm_t     lcm_value;
    operand_t gcd_value;
    logic     both_zero_error;
  } gcd_lcm_result_t;

  gcd_lcm_result_t predicted_results[$];

  // Euclid's remainder loop, then lcm as (a / gcd) * b at double width.
  function automatic gcd_lcm_result_t gcd_lcm_of(input operand_t a, input operand_t b);
    gcd_lcm_result_t res;
    operand_t        x;
    operand_t        y;
    operand_t        r;
    res = '0;
    if (a == '0 && b == '0) begin
      res.both_zero_error = 1'b1;
    end else begin
      x = a;
      y = b;
      while (y != '0) begin
        r = x % y;
        x = y;
        y = r;
      end
      res.gcd_value = x;
      if (a != '0 && b != '0) begin
        res.lcm_value = lcm_t'(a / x) * lcm_t'(b);
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin
    gcd_lcm_result_t want;
    int              fails;
    fails = fail_count;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        predicted_results.push_back(gcd_lcm_of(in_operand_a, in_operand_b));
      end
      if (out_valid && out_ready) begin
        if (predicted_results.size() == 0) begin
          $error("unexpected result item: lcm_value %0d gcd_value %0d both_zero_error %0d",
                 out_lcm_value, out_gcd_value, out_both_zero_error);
          fails++;
        end else begin
          want = predicted_results.pop_front();
          if (out_lcm_value !== want.lcm_value) begin
            $error("lcm_value: expected %0d, actual %0d", want.lcm_value, out_lcm_value);
            fails++;
          end
          if (out_gcd_value !== want.gcd_value) begin
            $error("gcd_value: expected %0d, actual %0d", want.gcd_value, out_gcd_value);
            fails++;
          end
          if (out_both_zero_error !== want.both_zero_error) begin
            $error("both_zero_error: expected %0d, actual %0d",
                   want.both_zero_error, out_both_zero_error);
            fails++;
          end
          checked_count <= checked_count + 1;
        end
      end
    end
    fail_count    <= fails;
    pending_count <= predicted_results.size();
  end

endmodule

### tb/lcm_via_euclid_gcd_unit_tb.sv
// Top of the gcd and lcm unit testbench: clock, reset, operand stimulus and verdict.
`timescale 1ns / 1ps

module lcm_via_euclid_gcd_unit_tb;

  localparam int OW             = 31;
  localparam int RANDOM_ITEMS   = 830;
  localparam int DRAIN_CYCLES   = 1600;
  localparam logic [OW-1:0] MAX = {OW{1'b1}};

  typedef logic [OW-1:0] operand_t;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            in_valid = 1'b0;
  logic            in_ready;
  operand_t        in_operand_a = '0;
  operand_t        in_operand_b = '0;
  logic            out_valid;
  logic            out_ready = 1'b0;
  logic [2*OW-1:0] out_lcm_value;
  operand_t        out_gcd_value;
  logic            out_both_zero_error;

  int pending_count;
  int fail_count;
  int checked_count;
  int sender_idle_pct   = 19;
  int receiver_idle_pct = 72;
  int pairs_sent        = 0;
  int zero_pairs_sent   = 0;

  lcm_via_euclid_gcd_unit #(
    .OPERAND_WIDTH(OW)
  ) i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_operand_a       (in_operand_a),
    .in_operand_b       (in_operand_b),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_lcm_value      (out_lcm_value),
    .out_gcd_value      (out_gcd_value),
    .out_both_zero_error(out_both_zero_error)
  );

  lcm_via_euclid_gcd_unit_checker #(
    .OPERAND_WIDTH(OW)
  ) i_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_operand_a       (in_operand_a),
    .in_operand_b       (in_operand_b),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_lcm_value      (out_lcm_value),
    .out_gcd_value      (out_gcd_value),
    .out_both_zero_error(out_both_zero_error),
    .pending_count      (pending_count),
    .fail_count         (fail_count),
    .checked_count      (checked_count)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #30_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= receiver_idle_pct);
  end

  // Fibonacci terms with fib_term(1) = fib_term(2) = 1; neighbors make Euclid run longest.
  function automatic operand_t fib_term(input int idx);
    operand_t prev;
    operand_t cur;
    operand_t nxt;
    prev = '0;
    cur  = operand_t'(1);
    for (int i = 1; i < idx; i++) begin
      nxt  = prev + cur;
      prev = cur;
      cur  = nxt;
    end
    return cur;
  endfunction

  // A random value of exactly nbits significant bits.
  function automatic operand_t value_of_length(input int nbits);
    operand_t mask;
    mask = MAX >> (OW - nbits);
    return (operand_t'($urandom) & mask) | (operand_t'(1) << (nbits - 1));
  endfunction

  task automatic send_pair(input operand_t a, input operand_t b);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_operand_a <= a;
    in_operand_b <= b;
    do @(posedge clk); while (!in_ready);
    pairs_sent++;
    if (a == '0 || b == '0) zero_pairs_sent++;
  endtask

  task automatic wait_until_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
  endtask

  task automatic send_random_pair();
    operand_t a;
    operand_t b;
    operand_t g;
    int       gbits;
    int       k;
    case ($urandom_range(19))
      0, 1, 2: begin
        a = operand_t'($urandom);
        b = operand_t'($urandom);
      end
      3, 4, 5, 6, 7, 8, 9: begin
        a = value_of_length($urandom_range(OW, 1));
        b = value_of_length($urandom_range(OW, 1));
      end
      10, 11, 12, 13, 14: begin
        // Shared factor so that the gcd is large.
        gbits = $urandom_range(OW - 1, 1);
        g     = value_of_length(gbits);
        a     = g * value_of_length($urandom_range(OW - gbits, 1));
        b     = g * value_of_length($urandom_range(OW - gbits, 1));
      end
      15: begin
        a = $urandom_range(1) ? '0 : value_of_length($urandom_range(OW, 1));
        b = $urandom_range(1) ? '0 : value_of_length($urandom_range(OW, 1));
      end
      16, 17: begin
        b = value_of_length($urandom_range(OW / 2, 1));
        a = $urandom_range(1) ? b : b * operand_t'($urandom_range(65535, 1));
        if ($urandom_range(1)) begin
          g = a;
          a = b;
          b = g;
        end
      end
      default: begin
        k = $urandom_range(46, 2);
        a = fib_term(k);
        b = fib_term(k - 1);
        if ($urandom_range(1)) begin
          g = a;
          a = b;
          b = g;
        end
      end
    endcase
    send_pair(a, b);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Zero operands, extremes, equal and coprime pairs, and the longest Euclid chains.
    send_pair('0, '0);
    send_pair('0, MAX);
    send_pair(MAX, '0);
    send_pair('0, operand_t'(1));
    send_pair(operand_t'(1), '0);
    send_pair(operand_t'(1), operand_t'(1));
    send_pair(MAX, MAX);
    send_pair(MAX, operand_t'(1));
    send_pair(operand_t'(1), MAX);
    send_pair(MAX, MAX - 1);
    send_pair(MAX - 1, MAX);
    send_pair(fib_term(46), fib_term(45));
    send_pair(fib_term(45), fib_term(46));
    send_pair(operand_t'(1) << (OW - 1), operand_t'(1) << (OW - 1));
    send_pair(operand_t'(1) << (OW - 1), operand_t'(3) << (OW - 3));
    send_pair(operand_t'(31'h5555_5555), operand_t'(31'h2AAA_AAAA));
    send_pair(operand_t'(2147483629), MAX);
    send_pair(operand_t'(12), operand_t'(18));
    send_pair(operand_t'(1000000), operand_t'(999999));
    send_pair('0, '0);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          sender_idle_pct   = 19;
          receiver_idle_pct = 72;
        end
        1: begin
          sender_idle_pct   = 72;
          receiver_idle_pct = 19;
        end
        default: begin
          sender_idle_pct   = 0;
          receiver_idle_pct = 0;
        end
      endcase
      for (int i = 0; i < RANDOM_ITEMS / 3; i++) begin
        send_random_pair();
      end
      // The sender holds off here until every outstanding result has come back.
      wait_until_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d operand pairs (%0d with a zero operand) over three idling phases,",
             pairs_sent, zero_pairs_sent);
    $display("and compared %0d results against the predicted gcd and lcm.", checked_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### files.f
rtl/lcmeg_pkg.sv
rtl/lcm_via_euclid_gcd_unit.sv
tb/lcm_via_euclid_gcd_unit_checker.sv
tb/lcm_via_euclid_gcd_unit_tb.sv
